### rtl/ocx_pkg.sv
// ----------------------------------------------------------------------------
// ocx_pkg
// Shared widths, defaults and controller/datapath handshake structs for the
// order crossover block.
// ----------------------------------------------------------------------------
package ocx_pkg;

  localparam int GENE_W          = 6;
  localparam int CNT_W           = 7;
  localparam int GENE_SPAN       = 64;
  localparam int MAX_CITIES_DEF  = 64;
  localparam logic [CNT_W-1:0] CITY_COUNT_RST = 7'd64;

  typedef struct packed {
    logic load_wr;
    logic cap_last;
    logic setup;
    logic rd_fp;
    logic init_scan;
    logic rd_sp;
    logic init_emit;
    logic rd_child;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic emit_ok;
  } stat_t;

endpackage

### rtl/ocx_ifs.sv
// ----------------------------------------------------------------------------
// ocx channel interfaces
// Valid/ready channels for parent words, child words and the city count.
// ----------------------------------------------------------------------------
interface ocx_in_if import ocx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GENE_W-1:0] first_parent_gene;
  logic [GENE_W-1:0] second_parent_gene;
  logic [GENE_W-1:0] cut_first;
  logic [GENE_W-1:0] cut_second;
  logic              last_position;

  modport source (output valid, first_parent_gene, second_parent_gene, cut_first,
                  cut_second, last_position, input ready);
  modport sink   (input valid, first_parent_gene, second_parent_gene, cut_first,
                  cut_second, last_position, output ready);
endinterface

interface ocx_out_if import ocx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GENE_W-1:0] child_gene;
  logic              child_last;

  modport source (output valid, child_gene, child_last, input ready);
  modport sink   (input valid, child_gene, child_last, output ready);
endinterface

interface ocx_cfg_if import ocx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] city_count;

  modport source (output valid, city_count, input ready);
  modport sink   (input valid, city_count, output ready);
endinterface

### rtl/ocx_ram.sv
// ----------------------------------------------------------------------------
// ocx_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ocx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ocx_ctrl.sv
// ----------------------------------------------------------------------------
// ocx_ctrl
// Phase sequencer: load, setup, segment sweep, cyclic scan, drain, emit.
// ----------------------------------------------------------------------------
module ocx_ctrl import ocx_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_last,
  output logic  in_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_SWEEP,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t state;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      in_ready <= 1'b1;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept && in_last) begin
            state    <= ST_SETUP;
            in_ready <= 1'b0;
          end
        end
        ST_SETUP: state <= ST_SWEEP;
        ST_SWEEP: begin
          if (stat.last) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (stat.last) state <= ST_DRAIN;
        end
        ST_DRAIN: state <= ST_EMIT;
        ST_EMIT: begin
          if (stat.emit_ok && stat.last) begin
            state    <= ST_LOAD;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_LOAD;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load_wr   = accept;
    cmd.cap_last  = accept && in_last;
    cmd.setup     = (state == ST_SETUP);
    cmd.rd_fp     = (state == ST_SWEEP);
    cmd.init_scan = (state == ST_SWEEP) && stat.last;
    cmd.rd_sp     = (state == ST_SCAN);
    cmd.init_emit = (state == ST_DRAIN);
    cmd.rd_child  = (state == ST_EMIT) && stat.emit_ok;
  end

endmodule

### rtl/ocx_datapath.sv
// ----------------------------------------------------------------------------
// ocx_datapath
// Parent and child stores, presence bitmap, position counters and the
// two-word output buffer.
// ----------------------------------------------------------------------------
module ocx_datapath import ocx_pkg::*; #(
  parameter int MAX_CITIES = MAX_CITIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [GENE_W-1:0] first_parent_gene,
  input  logic [GENE_W-1:0] second_parent_gene,
  input  logic [GENE_W-1:0] cut_first,
  input  logic [GENE_W-1:0] cut_second,
  ocx_out_if.source         child,
  ocx_cfg_if.sink           cfg
);

  localparam int AW = $clog2(MAX_CITIES);
  localparam int PW = $clog2(MAX_CITIES + 1);
  localparam int XW = (PW > CNT_W) ? PW : CNT_W;
  localparam int YW = (AW > GENE_W) ? AW : GENE_W;

  function automatic logic [AW-1:0] clamp_cut(input logic [GENE_W-1:0] raw,
                                              input logic [AW-1:0]     hi);
    logic [YW-1:0] c;
    c = YW'(raw);
    if (c == '0) c = YW'(1);
    if (c > YW'(hi)) c = YW'(hi);
    return AW'(c);
  endfunction

  logic [CNT_W-1:0]     city_count;
  logic [PW-1:0]        lp;
  logic [PW-1:0]        n;
  logic [PW-1:0]        n_next;
  logic [XW-1:0]        cc_x;
  logic [AW-1:0]        nm1;
  logic [GENE_W-1:0]    cut1_raw, cut2_raw;
  logic [AW-1:0]        c1, c2, c_lo, c_hi, start_next;
  logic [AW-1:0]        cut_lo, cut_hi, start;
  logic [AW-1:0]        pos, left, wr, pos_d, pos_inc;
  logic                 sweep_d, scan_d, emit_d, seg_d, last_d;
  logic [GENE_SPAN-1:0] present;

  logic                 par_we;
  logic [GENE_W-1:0]    fp_q, sp_q, ch_q;
  logic                 scan_ins;
  logic                 child_we;
  logic [AW-1:0]        child_waddr;
  logic [GENE_W-1:0]    child_wdata;

  logic [GENE_W-1:0]    q_gene [2];
  logic                 q_last [2];
  logic [1:0]           occ;
  logic [2:0]           fill;
  logic                 pop;
  logic                 push_head;

  // config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= CITY_COUNT_RST;
    end else if (cfg.valid) begin
      city_count <= cfg.city_count;
    end
  end

  always_comb begin
    cc_x = XW'(city_count);
    if (cc_x < XW'(3)) begin
      n_next = PW'(3);
    end else if (cc_x > XW'(MAX_CITIES)) begin
      n_next = PW'(MAX_CITIES);
    end else begin
      n_next = PW'(cc_x);
    end
  end

  assign nm1 = AW'(n - PW'(1));

  // load
  assign par_we = cmd.load_wr && (lp < PW'(MAX_CITIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      lp <= PW'(1);
    end else if (cmd.cap_last) begin
      lp <= PW'(1);
    end else if (par_we) begin
      lp <= lp + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_last) begin
      n        <= n_next;
      cut1_raw <= cut_first;
      cut2_raw <= cut_second;
    end
  end

  // cut ordering
  always_comb begin
    c1 = clamp_cut(cut1_raw, nm1);
    c2 = clamp_cut(cut2_raw, nm1);
    c_lo = (c1 > c2) ? c2 : c1;
    c_hi = (c1 > c2) ? c1 : c2;
    start_next = (c_hi == nm1) ? AW'(1) : c_hi + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      cut_lo <= c_lo;
      cut_hi <= c_hi;
      start  <= start_next;
    end
  end

  // position counters
  assign pos_inc = (pos == nm1) ? AW'(1) : pos + AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.setup || cmd.init_emit) begin
      pos  <= AW'(1);
      left <= nm1;
    end else if (cmd.init_scan) begin
      pos  <= start;
      left <= nm1;
    end else if (cmd.rd_fp || cmd.rd_sp || cmd.rd_child) begin
      pos  <= pos_inc;
      left <= left - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_scan) begin
      wr <= start;
    end else if (scan_ins) begin
      wr <= (wr == nm1) ? AW'(1) : wr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_d <= 1'b0;
      scan_d  <= 1'b0;
      emit_d  <= 1'b0;
    end else begin
      sweep_d <= cmd.rd_fp;
      scan_d  <= cmd.rd_sp;
      emit_d  <= cmd.rd_child;
    end
  end

  always_ff @(posedge clk) begin
    pos_d  <= pos;
    seg_d  <= (pos >= cut_lo) && (pos <= cut_hi);
    last_d <= (left == AW'(1));
  end

  // stores
  ocx_ram #(.WIDTH(GENE_W), .DEPTH(MAX_CITIES)) u_fp_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (lp[AW-1:0]),
    .wdata (first_parent_gene),
    .raddr (pos),
    .rdata (fp_q)
  );

  ocx_ram #(.WIDTH(GENE_W), .DEPTH(MAX_CITIES)) u_sp_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (lp[AW-1:0]),
    .wdata (second_parent_gene),
    .raddr (pos),
    .rdata (sp_q)
  );

  assign scan_ins    = scan_d && !present[sp_q];
  assign child_we    = sweep_d || scan_ins;
  assign child_waddr = sweep_d ? pos_d : wr;
  assign child_wdata = sweep_d ? (seg_d ? fp_q : '0) : sp_q;

  ocx_ram #(.WIDTH(GENE_W), .DEPTH(MAX_CITIES)) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .raddr (pos),
    .rdata (ch_q)
  );

  // presence bitmap, city zero set present at setup
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (cmd.setup) begin
      present <= GENE_SPAN'(1);
    end else begin
      if (sweep_d && seg_d) present[fp_q] <= 1'b1;
      if (scan_ins)         present[sp_q] <= 1'b1;
    end
  end

  // output buffer
  assign pop         = (occ != 2'd0) && child.ready;
  assign fill        = {1'b0, occ} + {2'b00, emit_d};
  assign push_head   = (occ == 2'd0) || ((occ == 2'd1) && pop);
  assign child.valid      = (occ != 2'd0);
  assign child.child_gene = q_gene[0];
  assign child.child_last = q_last[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 2'd0;
    end else begin
      case ({emit_d, pop})
        2'b10:   occ <= occ + 2'd1;
        2'b01:   occ <= occ - 2'd1;
        default: occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_d && push_head) begin
      q_gene[0] <= ch_q;
      q_last[0] <= last_d;
    end else if (pop) begin
      q_gene[0] <= q_gene[1];
      q_last[0] <= q_last[1];
    end
    if (emit_d && !push_head) begin
      q_gene[1] <= ch_q;
      q_last[1] <= last_d;
    end
  end

  assign stat.last    = (left == AW'(1));
  assign stat.emit_ok = (fill < 3'd2) || ((fill == 3'd2) && pop);

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ != 2'd3) else $error("output buffer overflow");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (emit_d && (occ == 2'd2)) |-> pop) else $error("push into full buffer");

  a_cut_order: assert property (@(posedge clk) disable iff (rst)
    cmd.setup |=> ((cut_lo <= cut_hi) && (cut_hi <= nm1) && (cut_lo != '0)))
    else $error("cut points out of order");

  a_child_pos: assert property (@(posedge clk) disable iff (rst)
    child_we |-> ((child_waddr != '0) && (child_waddr <= nm1)))
    else $error("child write outside interior");

endmodule

### rtl/order_crossover_permutation.sv
// ----------------------------------------------------------------------------
// order_crossover_permutation
// OX1 crossover of two tours: loads both parents one position per word, then
// copies the first parent's segment and fills the rest from the second parent.
// ----------------------------------------------------------------------------
// Parent words are taken one per cycle while loading. After the word marked
// last, the block stops taking input and runs the crossover on n = clamped
// city_count: a setup state, a sweep of the n-1 positions copying the segment
// and clearing the child, a scan of the second parent, a drain state, then n-1
// child words at up to one per cycle. Each phase is set by the single read
// port of its store, one position per cycle, with the emit phase held while
// the output buffer is full. Input is taken again once the last child word
// has been read from the store; the final words may still sit in the two-word
// output buffer.
module order_crossover_permutation import ocx_pkg::*; #(
  parameter int MAX_CITIES = MAX_CITIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ocx_in_if.sink    parent,
  ocx_out_if.source child,
  ocx_cfg_if.sink   cfg
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign parent.ready = in_ready;

  ocx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (parent.valid),
    .in_last  (parent.last_position),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ocx_datapath #(.MAX_CITIES(MAX_CITIES)) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .first_parent_gene  (parent.first_parent_gene),
    .second_parent_gene (parent.second_parent_gene),
    .cut_first          (parent.cut_first),
    .cut_second         (parent.cut_second),
    .child              (child),
    .cfg                (cfg)
  );

endmodule

### dv/tb_order_crossover_permutation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_order_crossover_permutation
// Self-checking bench for the OX1 crossover block. A directed table of short
// tours comes first. Random tours over many city counts follow, with random
// gaps on the parent and child channels. Every child word is compared with an
// in-bench crossover model or with the child genes typed into the table.
// ----------------------------------------------------------------------------
module tb_order_crossover_permutation import ocx_pkg::*; ();

  localparam int NCITY      = MAX_CITIES_DEF;
  localparam int RAND_WORDS = 430;
  localparam int SETTLE     = 8;
  localparam int TAIL       = 3 * NCITY + 16;
  localparam int NUM_DIR    = 25;

  typedef logic [GENE_W-1:0] gene_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef struct packed {
    gene_t first_parent_gene;
    gene_t second_parent_gene;
    gene_t cut_first;
    gene_t cut_second;
    logic  last_position;
  } parent_word_t;

  typedef struct packed {
    gene_t child_gene;
    logic  child_last;
  } child_word_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    count_t                 cities;
    parent_word_t           word;
    logic [1:0]             n_typed;
    logic [0:2][GENE_W-1:0] typed;
  } dir_row_t;

  // n_typed != 0: child genes typed in; otherwise the model supplies them
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{ROW_CFG,  7'd0, '{6'd0,  6'd0,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd1,  6'd2,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd2,  6'd1,  6'd0,  6'd0,  1'b1}, 2'd2, '{6'd1,  6'd2,  6'd0}},
    '{ROW_CFG,  7'd4, '{6'd0,  6'd0,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd1,  6'd3,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd2,  6'd2,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd3,  6'd1,  6'd63, 6'd63, 1'b1}, 2'd3, '{6'd2,  6'd1,  6'd3}},
    '{ROW_WORD, 7'd0, '{6'd3,  6'd1,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd1,  6'd2,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd2,  6'd3,  6'd3,  6'd1,  1'b1}, 2'd3, '{6'd3,  6'd1,  6'd2}},
    '{ROW_WORD, 7'd0, '{6'd1,  6'd0,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd1,  6'd0,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd1,  6'd0,  6'd2,  6'd2,  1'b1}, 2'd3, '{6'd0,  6'd1,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd5,  6'd63, 6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd6,  6'd62, 6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd7,  6'd61, 6'd1,  6'd1,  1'b1}, 2'd3, '{6'd63, 6'd62, 6'd61}},
    '{ROW_WORD, 7'd0, '{6'd2,  6'd3,  6'd2,  6'd3,  1'b1}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd3,  6'd1,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd1,  6'd3,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd2,  6'd2,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd63, 6'd0,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd0,  6'd63, 6'd0,  6'd2,  1'b1}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_CFG,  7'd3, '{6'd0,  6'd0,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd2,  6'd1,  6'd0,  6'd0,  1'b0}, 2'd0, '{6'd0,  6'd0,  6'd0}},
    '{ROW_WORD, 7'd0, '{6'd1,  6'd2,  6'd2,  6'd63, 1'b1}, 2'd2, '{6'd2,  6'd1,  6'd0}}
  };

  logic clk;
  logic rst;

  ocx_in_if  parent_ch ();
  ocx_out_if child_ch ();
  ocx_cfg_if cfg_ch ();

  order_crossover_permutation u_dut (
    .clk    (clk),
    .rst    (rst),
    .parent (parent_ch),
    .child  (child_ch),
    .cfg    (cfg_ch)
  );

  // crossover model state
  gene_t       fp_store [NCITY];
  gene_t       sp_store [NCITY];
  bit          loaded   [NCITY];
  int          load_pos = 1;
  count_t      city_count_q = CITY_COUNT_RST;
  child_word_t child_words_due [$];

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int parent_words_sent = 0;
  int tours_sent = 0;
  int settings_used = 0;
  int words_checked = 0;
  int fail_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int live_cities();
    if (city_count_q < 3) return 3;
    if (city_count_q > NCITY) return NCITY;
    return int'(city_count_q);
  endfunction

  function automatic int clamp_cut(gene_t raw, int n);
    int c;
    c = int'(raw);
    if (c < 1) c = 1;
    if (c > n - 1) c = n - 1;
    return c;
  endfunction

  function automatic void crossover_accept(parent_word_t w, output child_word_t kids[$]);
    int          n, a, b, t, start, wr, rd, i;
    gene_t       tour [NCITY];
    bit          seen [64];
    gene_t       g;
    child_word_t cw;
    kids = {};
    if (load_pos < NCITY) begin
      fp_store[load_pos] = w.first_parent_gene;
      sp_store[load_pos] = w.second_parent_gene;
      loaded[load_pos] = 1'b1;
      load_pos++;
    end
    if (!w.last_position) return;
    n = live_cities();
    a = clamp_cut(w.cut_first, n);
    b = clamp_cut(w.cut_second, n);
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    foreach (tour[j]) tour[j] = '0;
    foreach (seen[j]) seen[j] = 1'b0;
    seen[0] = 1'b1;
    for (i = a; i <= b; i++) begin
      tour[i] = fp_store[i];
      seen[fp_store[i]] = 1'b1;
    end
    start = (b + 1 >= n) ? 1 : b + 1;
    wr = start;
    rd = start;
    do begin
      g = sp_store[rd];
      if (!seen[g]) begin
        tour[wr] = g;
        seen[g] = 1'b1;
        wr++;
        if (wr >= n) wr = 1;
      end
      rd++;
      if (rd >= n) rd = 1;
    end while (rd != start);
    for (i = 1; i < n; i++) begin
      cw.child_gene = tour[i];
      cw.child_last = (i == n - 1);
      kids = {kids, cw};
    end
    load_pos = 1;
  endfunction

  function automatic void check_child_word(gene_t gene, logic last);
    child_word_t e;
    if (child_words_due.size() == 0) begin
      $error("unexpected child word: child_gene %0d child_last %0d", gene, last);
      fail_count++;
      return;
    end
    e = child_words_due.pop_front();
    if (gene !== e.child_gene) begin
      $error("child_gene: expected %0d, actual %0d", e.child_gene, gene);
      fail_count++;
    end
    if (last !== e.child_last) begin
      $error("child_last: expected %0d, actual %0d", e.child_last, last);
      fail_count++;
    end
    words_checked++;
  endfunction

  function automatic gene_t pick_cut(int n);
    if ($urandom_range(0, 3) == 0) return gene_t'($urandom_range(0, 63));
    return gene_t'($urandom_range(1, n - 1));
  endfunction

  function automatic count_t pick_city_count(int phase);
    if (phase == 0) return 7'd127;
    if (phase == 1) return 7'd64;
    case ($urandom_range(0, 29))
      0: return 7'd2;
      1: return 7'd1;
      2: return 7'd3;
      3: return count_t'($urandom_range(0, 127));
      default: return count_t'($urandom_range(3, 12));
    endcase
  endfunction

  task automatic send_word(parent_word_t w, child_word_t typed[$]);
    int          gap;
    child_word_t kids [$];
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      parent_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    parent_ch.valid              <= 1'b1;
    parent_ch.first_parent_gene  <= w.first_parent_gene;
    parent_ch.second_parent_gene <= w.second_parent_gene;
    parent_ch.cut_first          <= w.cut_first;
    parent_ch.cut_second         <= w.cut_second;
    parent_ch.last_position      <= w.last_position;
    @(posedge clk);
    while (!parent_ch.ready) @(posedge clk);
    crossover_accept(w, kids);
    if (typed.size() > 0) kids = typed;
    child_words_due = {child_words_due, kids};
    parent_words_sent++;
    if (w.last_position) tours_sent++;
    if ($urandom_range(0, 40) == 0) tx_steady = !tx_steady;
  endtask

  // wait for the block to go idle: every child word in, then a short settle
  task automatic drain_children();
    parent_ch.valid <= 1'b0;
    while (child_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_city_count(count_t v);
    drain_children();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.city_count <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    city_count_q = v;
    settings_used++;
  endtask

  // mostly shuffled tours; some with random genes, a duplicate, or odd length
  task automatic send_tour();
    int           n, len, mode, j, k;
    gene_t        tmp;
    gene_t        fp_tour [NCITY + 4];
    gene_t        sp_tour [NCITY + 4];
    parent_word_t w;
    child_word_t  none [$];
    n = live_cities();
    mode = $urandom_range(0, 9);
    len = n - 1;
    if (mode == 8) begin
      len = $urandom_range(1, n - 1);
      for (k = len + 1; k < n; k++) begin
        if (!loaded[k]) len = n - 1;
      end
    end else if (mode == 9) begin
      len = n - 1 + $urandom_range(1, 3);
    end
    for (k = 0; k < NCITY + 4; k++) begin
      fp_tour[k] = (k < n) ? gene_t'(k) : gene_t'($urandom_range(0, 63));
      sp_tour[k] = (k < n) ? gene_t'(k) : gene_t'($urandom_range(0, 63));
    end
    for (k = n - 1; k > 1; k--) begin
      j = $urandom_range(1, k);
      tmp = fp_tour[k];
      fp_tour[k] = fp_tour[j];
      fp_tour[j] = tmp;
      j = $urandom_range(1, k);
      tmp = sp_tour[k];
      sp_tour[k] = sp_tour[j];
      sp_tour[j] = tmp;
    end
    if (mode == 7) begin
      for (k = 1; k < NCITY + 4; k++) begin
        fp_tour[k] = gene_t'($urandom_range(0, 63));
        sp_tour[k] = gene_t'($urandom_range(0, 63));
      end
    end else if (mode == 6) begin
      sp_tour[$urandom_range(1, n - 1)] = sp_tour[$urandom_range(1, n - 1)];
      fp_tour[$urandom_range(1, n - 1)] = fp_tour[$urandom_range(1, n - 1)];
    end
    for (k = 1; k <= len; k++) begin
      w.first_parent_gene  = fp_tour[k];
      w.second_parent_gene = sp_tour[k];
      w.cut_first          = pick_cut(n);
      w.cut_second         = pick_cut(n);
      w.last_position      = (k == len);
      send_word(w, none);
    end
  endtask

  initial begin : child_sink
    int stall;
    child_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        child_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      child_ch.ready <= 1'b1;
      @(posedge clk);
      while (!child_ch.valid) @(posedge clk);
      check_child_word(child_ch.child_gene, child_ch.child_last);
      if ($urandom_range(0, 30) == 0) rx_steady = !rx_steady;
    end
  end

  initial begin : stimulus
    child_word_t typed [$];
    child_word_t cw;
    dir_row_t    row;
    int          r, k, phase, tours, base;
    rst                          <= 1'b1;
    parent_ch.valid              <= 1'b0;
    parent_ch.first_parent_gene  <= '0;
    parent_ch.second_parent_gene <= '0;
    parent_ch.cut_first          <= '0;
    parent_ch.cut_second         <= '0;
    parent_ch.last_position      <= 1'b0;
    cfg_ch.valid                 <= 1'b0;
    cfg_ch.city_count            <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < NUM_DIR; r++) begin
      row = DIR_ROWS[r];
      if (row.kind == ROW_CFG) begin
        write_city_count(row.cities);
      end else begin
        typed = {};
        for (k = 0; k < int'(row.n_typed); k++) begin
          cw.child_gene = row.typed[k];
          cw.child_last = (k == int'(row.n_typed) - 1);
          typed = {typed, cw};
        end
        send_word(row.word, typed);
      end
    end

    base = parent_words_sent;
    phase = 0;
    while (parent_words_sent - base < RAND_WORDS) begin
      write_city_count(pick_city_count(phase));
      tours = (live_cities() > 16) ? 1 : $urandom_range(1, 4);
      repeat (tours) begin
        send_tour();
        if ($urandom_range(0, 7) == 0) drain_children();
      end
      phase++;
    end

    drain_children();
    repeat (TAIL) @(posedge clk);
    $display("Ran %0d parent words as %0d tours under %0d city-count settings.",
             parent_words_sent, tours_sent, settings_used);
    $display("Compared %0d child words; %0d mismatches.", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $error("timeout: %0d child words still due", child_words_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
